### rtl/core/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the sorted list engine: command and status
// codes, field widths and the control word broadcast to the cell row.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int CMD_W    = 2;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    localparam logic signed [DATA_W-1:0] DATA_MISS = 32'hFFFF_FFFF;
    localparam logic signed [DATA_W-1:0] DATA_NONE = 32'h0000_0000;

    // Control word seen by every cell in the same cycle
    typedef struct packed {
        logic                     insert_en;
        logic                     remove_en;
        logic signed [DATA_W-1:0] value;
    } sle_ctrl_t;

endpackage

### rtl/core/sle_in_if.sv
// ----------------------------------------------------------------------------
// sle_in_if
// Command channel: valid/ready handshake carrying cmd, value and index.
// ----------------------------------------------------------------------------
interface sle_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [31:0] value;
    logic [3:0]         index;

    modport source (output valid, output cmd, output value, output index, input ready);
    modport sink   (input valid, input cmd, input value, input index, output ready);
endinterface

### rtl/core/sle_out_if.sv
// ----------------------------------------------------------------------------
// sle_out_if
// Result channel: valid/ready handshake carrying data, status, count, empty_res.
// ----------------------------------------------------------------------------
interface sle_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data;
    logic [1:0]         status;
    logic [4:0]         count;
    logic               empty_res;

    modport source (output valid, output data, output status, output count,
                    output empty_res, input ready);
    modport sink   (input valid, input data, input status, input count,
                    input empty_res, output ready);
endinterface

### rtl/core/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// One slot of the sorted row. Compares its entry against the broadcast value
// and either keeps it, takes the new value, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module sle_cell (
    input  logic                              clk,
    input  sle_pkg::sle_ctrl_t                ctrl,
    input  logic                              occupied,
    input  logic                              left_lt,
    input  logic signed [sle_pkg::DATA_W-1:0] left_value,
    input  logic signed [sle_pkg::DATA_W-1:0] right_value,
    output logic signed [sle_pkg::DATA_W-1:0] value,
    output logic                              lt
);
    import sle_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;

    // Sorted row: lt is a prefix, so the first cell with lt low is the slot
    assign lt = occupied && (value_reg < ctrl.value);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert_en && !lt)
        begin
            value_next = left_lt ? ctrl.value : left_value;
        end
        else if (ctrl.remove_en)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

### rtl/core/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine
// Priority queue of signed 32-bit values kept in ascending order in a row of
// cells.
// ----------------------------------------------------------------------------
// The engine takes one command per clock cycle and answers each with one
// result, registered and shown the cycle after the command transfer. Every
// cell holds one entry and owns one signed comparator, so an insert, a remove
// of the smallest entry and a clear all take effect at once whatever
// the fill level; a read selects one of the first sixteen cells. A stalled
// result holds off the next command until it is taken. Contents are not
// cleared after reset: only positions below the entry count are ever read.
// ----------------------------------------------------------------------------
module sorted_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    sle_in_if.sink      in_ch,
    sle_out_if.source   out_ch
);
    import sle_pkg::*;

    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int CMPW     = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int RD_DEPTH = (CAPACITY < (1 << INDEX_W)) ? CAPACITY : (1 << INDEX_W);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    status_t                  status_reg;
    status_t                  status_next;
    logic [COUNT_W-1:0]       count_out_reg;
    logic                     empty_reg;

    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    sle_ctrl_t                ctrl;

    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic                     cell_lt    [CAPACITY];

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign full        = (count_reg == CW'(CAPACITY));
    assign empty       = (count_reg == '0);
    assign hit         = (CMPW'(in_ch.index) < CMPW'(count_reg));

    // Broadcast to the cell row; only a transfer may change the entries
    always_comb
    begin
        ctrl.insert_en = accept && (cmd_t'(in_ch.cmd) == CMD_INSERT) && !full;
        ctrl.remove_en = accept && (cmd_t'(in_ch.cmd) == CMD_REMOVE) && !empty;
        ctrl.value     = in_ch.value;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                     left_lt;
        logic signed [DATA_W-1:0] left_value;
        logic signed [DATA_W-1:0] right_value;

        if (i == 0)
        begin : g_head
            assign left_lt    = 1'b1;
            assign left_value = in_ch.value;
        end
        else
        begin : g_body
            assign left_lt    = cell_lt[i-1];
            assign left_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value = cell_value[i];
        end
        else
        begin : g_mid
            assign right_value = cell_value[i+1];
        end

        sle_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .occupied    (CW'(i) < count_reg),
            .left_lt     (left_lt),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .lt          (cell_lt[i])
        );
    end

    // Read port over the cells reachable by the index field
    always_comb
    begin
        read_value = DATA_NONE;
        for (int j = 0; j < RD_DEPTH; j++)
        begin
            if (in_ch.index == INDEX_W'(j))
            begin
                read_value = cell_value[j];
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        data_next   = DATA_NONE;
        status_next = ST_OK;
        unique case (cmd_t'(in_ch.cmd))
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_READ:
            begin
                if (hit)
                begin
                    data_next = read_value;
                end
                else
                begin
                    data_next   = DATA_MISS;
                    status_next = ST_MISS;
                end
            end
            CMD_REMOVE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on transfer, hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg      <= data_next;
            status_reg    <= status_next;
            count_out_reg <= COUNT_W'(count_next);
            empty_reg     <= (count_next == '0);
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.data      = data_reg;
    assign out_ch.status    = status_reg;
    assign out_ch.count     = count_out_reg;
    assign out_ch.empty_res = empty_reg;

`ifndef SYNTH
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> out_ch.valid)
        else $error("no result after command transfer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && (cmd_t'(in_ch.cmd) == CMD_INSERT) && full
        |=> out_ch.status == ST_FULL && $stable(count_reg))
        else $error("insert into full store changed the count");

    a_remove_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.remove_en |=> count_reg == $past(count_reg) - CW'(1))
        else $error("remove did not drop exactly one entry");
`endif

endmodule

### tb/sorted_list_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_engine_tb
// Self-checking bench for the sorted list engine. A short table of commands
// covers the empty and full store, signed extremes, duplicates and read
// misses. Random phases of inserts, reads, removes and clears follow, with
// random gaps on both channels. Every result is checked against typed-in
// values or a predictor that keeps its own sorted copy of the store.
// ----------------------------------------------------------------------------
module sorted_list_engine_tb;

    import sle_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RANDOM_PHASES  = 15;
    localparam int PHASE_ITEMS    = 100;
    localparam int LONG_HOLD      = 80;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_OPENING      = 27;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        status_t                  status;
        logic [COUNT_W-1:0]       count;
        logic                     empty_res;
    } result_t;

    typedef struct packed {
        cmd_t                     op;
        logic signed [DATA_W-1:0] val;
        logic [INDEX_W-1:0]       idx;
        logic                     fixed;
        result_t                  want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sle_in_if  cmd_ch ();
    sle_out_if res_ch ();

    sorted_list_engine #(
        .CAPACITY (DEPTH)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch),
        .out_ch (res_ch)
    );

    // Predictor state: sorted copy of the store
    logic signed [DATA_W-1:0] list_vals [DEPTH];
    int                       list_count;

    result_t results_due [$];
    int      mismatches;
    int      quiet_cycles;

    // Per-item side data, driven together with the command fields
    logic    row_fixed;
    result_t row_want;

    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;

    // Commands whose result is plain to see are typed in; others use the predictor
    stim_row_t opening_rows [N_OPENING] = '{
        '{CMD_READ,   32'sd0,         4'd0,  1'b1, '{DATA_MISS, ST_MISS,  5'd0,  1'b1}},
        '{CMD_REMOVE, 32'sd0,         4'd0,  1'b1, '{DATA_NONE, ST_EMPTY, 5'd0,  1'b1}},
        '{CMD_CLEAR,  32'sd0,         4'd0,  1'b1, '{DATA_NONE, ST_OK,    5'd0,  1'b1}},
        '{CMD_INSERT, 32'sh7FFF_FFFF, 4'd0,  1'b1, '{DATA_NONE, ST_OK,    5'd1,  1'b0}},
        '{CMD_INSERT, 32'sh8000_0000, 4'd0,  1'b1, '{DATA_NONE, ST_OK,    5'd2,  1'b0}},
        '{CMD_READ,   32'sd0,         4'd0,  1'b1, '{32'sh8000_0000, ST_OK, 5'd2, 1'b0}},
        '{CMD_READ,   32'sd0,         4'd1,  1'b1, '{32'sh7FFF_FFFF, ST_OK, 5'd2, 1'b0}},
        '{CMD_READ,   32'sd0,         4'd2,  1'b1, '{DATA_MISS, ST_MISS,  5'd2,  1'b0}},
        '{CMD_INSERT, 32'sd0,         4'd0,  1'b0, '0},
        '{CMD_INSERT, -32'sd1,        4'd0,  1'b0, '0},
        '{CMD_INSERT, 32'sd5,         4'd0,  1'b0, '0},
        '{CMD_INSERT, 32'sd5,         4'd0,  1'b0, '0},
        '{CMD_INSERT, 32'sh7FFF_FFFF, 4'd0,  1'b0, '0},
        '{CMD_INSERT, 32'sh8000_0000, 4'd0,  1'b0, '0},
        '{CMD_READ,   32'sd0,         4'd15, 1'b0, '0},
        '{CMD_INSERT, 32'sd3,         4'd0,  1'b0, '0},
        '{CMD_INSERT, -32'sd3,        4'd0,  1'b0, '0},
        '{CMD_INSERT, 32'sd100,       4'd0,  1'b0, '0},
        '{CMD_INSERT, -32'sd100,      4'd0,  1'b0, '0},
        '{CMD_INSERT, 32'sd1,         4'd0,  1'b0, '0},
        '{CMD_INSERT, 32'sd2,         4'd0,  1'b0, '0},
        '{CMD_INSERT, 32'sd7,         4'd0,  1'b0, '0},
        '{CMD_INSERT, -32'sd7,        4'd0,  1'b0, '0},
        '{CMD_INSERT, 32'sd42,        4'd0,  1'b1, '{DATA_NONE, ST_FULL,  5'd16, 1'b0}},
        '{CMD_READ,   32'sd0,         4'd15, 1'b0, '0},
        '{CMD_REMOVE, 32'sd0,         4'd0,  1'b0, '0},
        '{CMD_CLEAR,  32'sd0,         4'd0,  1'b1, '{DATA_NONE, ST_OK,    5'd0,  1'b1}}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one command to the sorted copy and return the result it yields
    function automatic result_t apply_to_list(cmd_t op, logic signed [DATA_W-1:0] val,
                                              logic [INDEX_W-1:0] idx);
        result_t r;
        int      pos;
        int      i;
        r.data   = DATA_NONE;
        r.status = ST_OK;
        case (op)
            CMD_INSERT:
            begin
                if (list_count >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < list_count && list_vals[pos] < val)
                        pos++;
                    for (i = list_count; i > pos; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[pos] = val;
                    list_count++;
                end
            end
            CMD_READ:
            begin
                if (int'(idx) < list_count)
                begin
                    r.data = list_vals[idx];
                end
                else
                begin
                    r.data   = DATA_MISS;
                    r.status = ST_MISS;
                end
            end
            CMD_REMOVE:
            begin
                if (list_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    for (i = 1; i < list_count; i++)
                        list_vals[i-1] = list_vals[i];
                    list_count--;
                end
            end
            default:
            begin
                list_count = 0;
            end
        endcase
        r.count     = list_count[COUNT_W-1:0];
        r.empty_res = (list_count == 0);
        return r;
    endfunction

    task automatic log_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Offer one command, after a random gap if tx_idle_on is set, and hold it until the transfer
    task automatic send_cmd(input cmd_t op, input logic signed [DATA_W-1:0] val,
                            input logic [INDEX_W-1:0] idx, input logic fixed,
                            input result_t want);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd   <= op;
        cmd_ch.value <= val;
        cmd_ch.index <= idx;
        row_fixed    <= fixed;
        row_want     <= want;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $signed(32'($urandom_range(0, 16))) - 32'sd8;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $signed($urandom);
        endcase
    endfunction

    // Result receiver with random back-pressure
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                stall    = LONG_HOLD;
                hold_req = 1'b0;
            end
            else
            begin
                stall = rx_idle_on ? $urandom_range(0, 14) : 0;
            end
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    // Check results first, then record the command taken at the same edge
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (results_due.size() == 0)
                begin
                    log_mismatch("result transfer with nothing outstanding");
                end
                else
                begin
                    want = results_due.pop_front();
                    if (res_ch.data !== want.data)
                        log_mismatch($sformatf("data %0d, want %0d", res_ch.data, want.data));
                    if (res_ch.status !== want.status)
                        log_mismatch($sformatf("status %0d, want %0d",
                                               res_ch.status, want.status));
                    if (res_ch.count !== want.count)
                        log_mismatch($sformatf("count %0d, want %0d",
                                               res_ch.count, want.count));
                    if (res_ch.empty_res !== want.empty_res)
                        log_mismatch($sformatf("empty_res %0b, want %0b",
                                               res_ch.empty_res, want.empty_res));
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                want = apply_to_list(cmd_t'(cmd_ch.cmd), cmd_ch.value, cmd_ch.index);
                results_due.push_back(row_fixed ? row_want : want);
            end
        end
    end

    // Watchdog: end the run when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sorted_list_engine_tb: FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        cmd_t op;
        int   ins_pct;
        int   pick;
        cmd_ch.valid = 1'b0;
        cmd_ch.cmd   = CMD_INSERT;
        cmd_ch.value = '0;
        cmd_ch.index = '0;
        row_fixed    = 1'b0;
        row_want     = '0;
        tx_idle_on   = 1'b1;
        rx_idle_on   = 1'b1;
        hold_req     = 1'b0;
        mismatches   = 0;
        list_count   = 0;
        rst_n        = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (opening_rows[k])
            send_cmd(opening_rows[k].op, opening_rows[k].val, opening_rows[k].idx,
                     opening_rows[k].fixed, opening_rows[k].want);
        drain_results();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            tx_idle_on = (p % 3 != 1);
            rx_idle_on = (p % 4 != 2);
            case (p % 3)
                0: ins_pct = 75;
                1: ins_pct = 50;
                default: ins_pct = 30;
            endcase
            // Flood a stalled output so the block backs up its input
            if (p == 1)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    op = CMD_CLEAR;
                else if (pick < 33)
                    op = CMD_READ;
                else if ($urandom_range(0, 99) < ins_pct)
                    op = CMD_INSERT;
                else
                    op = CMD_REMOVE;
                send_cmd(op, pick_value(), INDEX_W'($urandom_range(0, 15)), 1'b0, '0);
            end
            if (p % 4 == 3)
                drain_results();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("sorted_list_engine_tb: PASS");
        else
            $display("sorted_list_engine_tb: FAIL");
        $finish;
    end

endmodule
